// ===== rtl/conv1d_leaky_relu_maxpool_assert.svh =====
// Assertion macros used by the checker of the convolution, leaky ReLU and max pooling block.
`ifndef CONV1D_LEAKY_RELU_MAXPOOL_ASSERT_SVH
`define CONV1D_LEAKY_RELU_MAXPOOL_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CLRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CLRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CLRM_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clrm_pkg.sv =====
// Constants, types and register codes of the convolution, leaky ReLU and max pooling block.
`default_nettype none

package clrm_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_FRAC = 14;
  localparam int LEAK_BITS   = 16;
  localparam int LEAK_FRAC   = 16;
  localparam int WIDX_W      = 4;

  localparam int TAPS_REG_W   = 5;
  localparam int STRIDE_REG_W = 3;
  localparam int BIAS_W       = 32;
  localparam int POOL_REG_W   = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int MAX_STRIDE = 4;
  localparam int MAX_POOL   = 8;
  localparam int PHASE_W    = 2;
  localparam int POOLCNT_W  = 3;

  localparam int TAP_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
  localparam int DOT_W  = PROD_W + TAP_W;
  localparam int ACC_W  = ((DOT_W > BIAS_W) ? DOT_W : BIAS_W) + 1;

  // The leak multiply is split into a low unsigned and a high signed partial product.
  localparam int LO_W      = (ACC_W + 1) / 2;
  localparam int HI_W      = ACC_W - LO_W;
  localparam int PLO_W     = LO_W + LEAK_BITS;
  localparam int PHI_W     = HI_W + LEAK_BITS + 1;
  localparam int PSUM_W    = PHI_W + 1;
  localparam int NEG_SHIFT = WEIGHT_FRAC + LEAK_FRAC - LO_W;
  localparam int VAL_W     = PSUM_W - NEG_SHIFT;
  localparam int POS_W     = ACC_W - WEIGHT_FRAC;

  localparam logic [TAPS_REG_W-1:0]   TAPS_RST   = 5'd10;
  localparam logic [STRIDE_REG_W-1:0] STRIDE_RST = 3'd2;
  localparam logic [BIAS_W-1:0]       BIAS_RST   = 32'd0;
  localparam logic [LEAK_BITS-1:0]    LEAK_RST   = 16'd6554;
  localparam logic [POOL_REG_W-1:0]   POOL_RST   = 4'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAPS   = 3'd0,
    CFG_STRIDE = 3'd1,
    CFG_BIAS   = 3'd2,
    CFG_LEAK   = 3'd3,
    CFG_POOL   = 3'd4
  } cfg_idx_t;

  // Partial sum travelling down the cell chain.
  typedef struct packed {
    logic vld;
    acc_t sum;
  } sum_tok_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic    vld;
    sample_t act;
  } post_res_t;

endpackage

`default_nettype wire

// ===== rtl/clrm_in_if.sv =====
// Input channel: samples and weight loads with a valid/ready handshake.
`default_nettype none

interface clrm_in_if import clrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  sample_t             sample;
  logic                last_sample;
  logic [WIDX_W-1:0]   weight_index;
  weight_t             weight_value;

  modport source (output valid, cmd, sample, last_sample, weight_index, weight_value,
                  input ready);
  modport sink (input valid, cmd, sample, last_sample, weight_index, weight_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/clrm_out_if.sv =====
// Output channel: pooled results with a valid/ready handshake.
`default_nettype none

interface clrm_out_if import clrm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t pooled_value;
  logic    has_value;
  logic    frame_end;

  modport source (output valid, pooled_value, has_value, frame_end, input ready);
  modport sink (input valid, pooled_value, has_value, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/clrm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module clrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/clrm_cell.sv =====
// One cell of the convolution chain: a window sample and a multiply-accumulate stage.
`default_nettype none

module clrm_cell import clrm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  sample_t    sample_in,
  output sample_t    sample_out,
  input  weight_t    weight,
  input  logic       tap_on,
  input  sum_tok_t   tok_in,
  output sum_tok_t   tok_out
);

  sample_t                  smp;
  logic signed [PROD_W-1:0] prod;
  acc_t                     addend;
  acc_t                     sum;
  logic                     vld;

  always_comb begin
    prod   = smp * weight;
    addend = tap_on ? ACC_W'(prod) : '0;
  end

  // Window samples shift one cell per accepted sample; a frame end empties the window.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      smp <= '0;
    end else if (ctrl.shift) begin
      smp <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    sum <= tok_in.sum + addend;
  end

  assign sample_out  = smp;
  assign tok_out.vld = vld;
  assign tok_out.sum = sum;

endmodule

`default_nettype wire

// ===== rtl/clrm_post.sv =====
// Leaky ReLU, rescale to Q7.8 and saturation, as a three-stage pipeline.
`default_nettype none

module clrm_post import clrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  sum_tok_t             acc_in,
  input  logic [LEAK_BITS-1:0] leak,
  output post_res_t            res
);

  logic [PLO_W-1:0]         plo;
  logic                     vld1;
  acc_t                     acc1;
  logic [LEAK_BITS-1:0]     plo_top1;

  logic signed [PHI_W-1:0]  phi;
  logic                     vld2;
  logic signed [PHI_W-1:0]  phi2;
  logic [LEAK_BITS-1:0]     plo_top2;
  logic                     neg2;
  logic signed [POS_W-1:0]  pos2;

  logic signed [PSUM_W-1:0] psum;
  logic signed [VAL_W-1:0]  negv;
  logic signed [VAL_W-1:0]  val;
  sample_t                  act;
  logic                     vld3;
  sample_t                  act3;

  always_comb begin
    plo = acc_in.sum[LO_W-1:0] * leak;
    phi = $signed(acc1[ACC_W-1:LO_W]) * $signed({1'b0, leak});
    // Only the bits of the low product above the split point reach the result.
    psum = {phi2[PHI_W-1], phi2} + {{(PSUM_W - LEAK_BITS){1'b0}}, plo_top2};
    negv = psum[PSUM_W-1:NEG_SHIFT];
    val  = neg2 ? negv : {{(VAL_W - POS_W){pos2[POS_W-1]}}, pos2};
    if (val > VAL_W'(SAMPLE_MAX)) begin
      act = SAMPLE_MAX;
    end else if (val < VAL_W'(SAMPLE_MIN)) begin
      act = SAMPLE_MIN;
    end else begin
      act = val[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= acc_in.vld;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    acc1     <= acc_in.sum;
    plo_top1 <= plo[PLO_W-1:LO_W];
    phi2     <= phi;
    plo_top2 <= plo_top1;
    neg2     <= acc1[ACC_W-1];
    pos2     <= acc1[ACC_W-1:WEIGHT_FRAC];
    act3     <= act;
  end

  assign res.vld = vld3;
  assign res.act = act3;

endmodule

`default_nettype wire

// ===== rtl/conv1d_leaky_relu_maxpool.sv =====
// Top level: 1-D convolution, leaky ReLU and max pooling over a sample stream.
`default_nettype none

// A weight load and a sample that does not complete a convolution output leave
// the block idle; a sample that ends the frame first passes the emit state. A
// sample that triggers a convolution output passes the prime, run and post
// states: the partial sum walks the chain of MAX_TAPS cells one cell per cycle,
// reading one weight per cycle from the weight RAM, and then passes the three-stage
// leaky ReLU pipeline; the emit state follows when a result word is produced, and
// it waits while the output register is held by a stalled consumer. One word is
// processed at a time. The weight RAM has no reset: every tap in use must be
// loaded before the first convolution output of a frame.
module conv1d_leaky_relu_maxpool import clrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  clrm_in_if.sink               din,
  clrm_out_if.source            dout,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRIME = 5'b00010,
    S_RUN   = 5'b00100,
    S_POST  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  logic [TAPS_REG_W-1:0]   taps_in_use;
  logic [STRIDE_REG_W-1:0] conv_stride;
  logic signed [BIAS_W-1:0] bias;
  logic [LEAK_BITS-1:0]    leak_coef;
  logic [POOL_REG_W-1:0]   pool_len;

  logic [CNT_W-1:0]        taps_c;
  logic [STRIDE_REG_W-1:0] stride_c;
  logic [POOL_REG_W-1:0]   plen_c;

  state_t                  state;
  logic [CNT_W-1:0]        seen;
  logic [PHASE_W-1:0]      phase;
  logic [POOLCNT_W-1:0]    pool_count;
  sample_t                 pool_max;
  logic                    last_r;
  logic                    inject;
  logic [TAP_W-1:0]        cur_cell;

  logic                    res_has;
  sample_t                 res_value;
  logic                    res_last;
  logic                    out_valid;
  logic                    out_has;
  sample_t                 out_value;
  logic                    out_last;

  logic                    in_acc;
  logic                    data_acc;
  logic [CNT_W-1:0]        seen_inc;
  logic                    full;
  logic                    conv_go;
  logic [STRIDE_REG_W-1:0] phase_p1;
  logic [PHASE_W-1:0]      phase_adv;
  logic                    pool_done;
  sample_t                 pmax_new;
  logic [TAP_W-1:0]        rd_cell;
  logic [TAP_W-1:0]        raddr;
  logic                    w_we;
  weight_t                 w_rdata;
  cell_ctrl_t              ctrl;
  post_res_t               post_res;

  sample_t                 win     [MAX_TAPS];
  sample_t                 cell_in [MAX_TAPS];
  sum_tok_t                tok     [MAX_TAPS];
  sum_tok_t                tok_in  [MAX_TAPS];
  logic [MAX_TAPS-1:0]     tap_on;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= TAPS_RST;
      conv_stride <= STRIDE_RST;
      bias        <= BIAS_RST;
      leak_coef   <= LEAK_RST;
      pool_len    <= POOL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAPS:   taps_in_use <= cfg_data[TAPS_REG_W-1:0];
        CFG_STRIDE: conv_stride <= cfg_data[STRIDE_REG_W-1:0];
        CFG_BIAS:   bias        <= cfg_data[BIAS_W-1:0];
        CFG_LEAK:   leak_coef   <= cfg_data[LEAK_BITS-1:0];
        CFG_POOL:   pool_len    <= cfg_data[POOL_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (taps_in_use == '0) begin
      taps_c = CNT_W'(1);
    end else if (32'(taps_in_use) > MAX_TAPS) begin
      taps_c = CNT_W'(MAX_TAPS);
    end else begin
      taps_c = CNT_W'(taps_in_use);
    end
    if (conv_stride == '0) begin
      stride_c = STRIDE_REG_W'(1);
    end else if (32'(conv_stride) > MAX_STRIDE) begin
      stride_c = STRIDE_REG_W'(MAX_STRIDE);
    end else begin
      stride_c = conv_stride;
    end
    if (pool_len == '0) begin
      plen_c = POOL_REG_W'(1);
    end else if (32'(pool_len) > MAX_POOL) begin
      plen_c = POOL_REG_W'(MAX_POOL);
    end else begin
      plen_c = pool_len;
    end
  end

  assign din.ready = (state == S_IDLE);
  assign in_acc    = din.valid && din.ready;
  assign data_acc  = in_acc && !din.cmd;

  always_comb begin
    seen_inc  = (seen == CNT_W'(MAX_TAPS)) ? seen : seen + CNT_W'(1);
    full      = (seen_inc >= taps_c);
    conv_go   = full && (phase == '0);
    phase_p1  = STRIDE_REG_W'(phase) + STRIDE_REG_W'(1);
    phase_adv = (phase_p1 >= stride_c) ? '0 : PHASE_W'(phase_p1);
    pool_done = (POOL_REG_W'(pool_count) + POOL_REG_W'(1)) >= plen_c;
    pmax_new  = (post_res.act > pool_max) ? post_res.act : pool_max;
    // The weight is read in the cycle before the cell that uses it.
    rd_cell   = (state == S_PRIME) ? TAP_W'(MAX_TAPS - 1) : cur_cell - TAP_W'(1);
    raddr     = TAP_W'(taps_c - CNT_W'(1) - CNT_W'(rd_cell));
    w_we      = in_acc && din.cmd && (32'(din.weight_index) < MAX_TAPS);
    ctrl.shift = data_acc;
    ctrl.clear = (data_acc && !conv_go && din.last_sample) ||
                 ((state == S_POST) && post_res.vld && last_r);
  end

  clrm_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_TAPS)
  ) u_wram (
    .clk   (clk),
    .we    (w_we),
    .waddr (TAP_W'(din.weight_index)),
    .wdata (din.weight_value),
    .raddr (raddr),
    .rdata (w_rdata)
  );

  // Cell k holds the k-th newest sample; the sum enters at the far end and moves toward cell 0.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cell_in[k] = din.sample;
    end else begin : g_next
      assign cell_in[k] = win[k-1];
    end
    if (k == MAX_TAPS - 1) begin : g_head
      assign tok_in[k].vld = inject;
      assign tok_in[k].sum = ACC_W'(bias);
    end else begin : g_link
      assign tok_in[k] = tok[k+1];
    end
    assign tap_on[k] = (CNT_W'(k) < taps_c);

    clrm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample_in  (cell_in[k]),
      .sample_out (win[k]),
      .weight     (w_rdata),
      .tap_on     (tap_on[k]),
      .tok_in     (tok_in[k]),
      .tok_out    (tok[k])
    );
  end

  clrm_post u_post (
    .clk    (clk),
    .rst    (rst),
    .acc_in (tok[0]),
    .leak   (leak_coef),
    .res    (post_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seen       <= '0;
      phase      <= '0;
      pool_count <= '0;
      pool_max   <= SAMPLE_MIN;
      last_r     <= 1'b0;
      inject     <= 1'b0;
      cur_cell   <= '0;
      out_valid  <= 1'b0;
    end else begin
      inject <= (state == S_PRIME);
      if ((state == S_EMIT) && (!out_valid || dout.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (data_acc) begin
            last_r <= din.last_sample;
            if (conv_go) begin
              seen  <= seen_inc;
              phase <= phase_adv;
              state <= S_PRIME;
            end else if (din.last_sample) begin
              seen       <= '0;
              phase      <= '0;
              pool_count <= '0;
              pool_max   <= SAMPLE_MIN;
              res_has    <= 1'b0;
              res_value  <= '0;
              res_last   <= 1'b1;
              state      <= S_EMIT;
            end else begin
              seen <= seen_inc;
              if (full) begin
                phase <= phase_adv;
              end
            end
          end
        end
        S_PRIME: begin
          cur_cell <= TAP_W'(MAX_TAPS - 1);
          state    <= S_RUN;
        end
        S_RUN: begin
          cur_cell <= cur_cell - TAP_W'(1);
          if (cur_cell == '0) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (post_res.vld) begin
            res_last  <= last_r;
            res_has   <= pool_done;
            res_value <= pool_done ? pmax_new : '0;
            if (last_r) begin
              seen       <= '0;
              phase      <= '0;
              pool_count <= '0;
              pool_max   <= SAMPLE_MIN;
            end else if (pool_done) begin
              pool_count <= '0;
              pool_max   <= SAMPLE_MIN;
            end else begin
              pool_count <= pool_count + POOLCNT_W'(1);
              pool_max   <= pmax_new;
            end
            state <= (pool_done || last_r) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || dout.ready) begin
            out_has   <= res_has;
            out_value <= res_value;
            out_last  <= res_last;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign dout.valid        = out_valid;
  assign dout.pooled_value = out_value;
  assign dout.has_value    = out_has;
  assign dout.frame_end    = out_last;

endmodule

`default_nettype wire

// ===== rtl/clrm_chk.sv =====
// Port-level checker for the convolution block, bound to the top level.
`default_nettype none

`include "conv1d_leaky_relu_maxpool_assert.svh"

module clrm_chk import clrm_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    in_cmd,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_value,
  input logic    out_has,
  input logic    out_last
);

  // A stalled result word must hold.
  `CLRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_has) && $stable(out_last), "result word changed while stalled")

  // A word without a value only closes a frame, and carries a zero value.
  `CLRM_ASSERT_IMP(a_empty_word, out_valid && !out_has, out_last && (out_value == '0), "empty result word outside a frame end")

  // A weight load never holds up the input.
  `CLRM_ASSERT_NEXT(a_wload_ready, in_valid && in_ready && in_cmd, in_ready, "input stalled after a weight load")

  // Reset leaves no result word pending.
  `CLRM_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid, "result word valid after reset")

endmodule

bind conv1d_leaky_relu_maxpool clrm_chk u_clrm_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .in_cmd    (din.cmd),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_value (dout.pooled_value),
  .out_has   (dout.has_value),
  .out_last  (dout.frame_end)
);

`default_nettype wire
